[hdl/lbdr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lbdr_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int TILE_W      = 8;
  localparam int DIM_CFG_W   = 5;
  localparam int LINK_W      = 4;
  localparam int TURN_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int PORT_W      = 3;

  typedef logic [PORT_W-1:0] port_t;

  localparam port_t PORT_LOCAL = 3'd0;
  localparam port_t PORT_NORTH = 3'd1;
  localparam port_t PORT_EAST  = 3'd2;
  localparam port_t PORT_SOUTH = 3'd3;
  localparam port_t PORT_WEST  = 3'd4;
  localparam port_t PORT_NONE  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_MESH_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MESH_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_TILE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_HEALTHY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_BITS    = 3'd4;

  localparam logic [DIM_CFG_W-1:0] MESH_COLUMNS_RST = 5'd4;
  localparam logic [DIM_CFG_W-1:0] MESH_ROWS_RST    = 5'd4;
  localparam logic [TILE_W-1:0]    OWN_TILE_RST     = 8'd0;
  localparam logic [LINK_W-1:0]    LINK_HEALTHY_RST = 4'hF;
  localparam logic [TURN_W-1:0]    TURN_BITS_RST    = 8'hFF;

  // link bits
  localparam int LINK_N = 0;
  localparam int LINK_E = 1;
  localparam int LINK_S = 2;
  localparam int LINK_W_BIT = 3;

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [TURN_W-1:0] turn;
  } route_cfg_t;

endpackage

`default_nettype wire

[hdl/lbdr_mesh_route_select_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// LBDR route selector: takes one target tile per cycle and returns the output port
// (local, N, E, S, W or no route). A row of 8 divider cells, one quotient bit
// each, splits the target and own tile into row and column, and a final register
// holds the decision. Throughput is one beat per cycle; the whole pipeline holds
// while a result waits on out_ready. Write config only when idle.
module lbdr_mesh_route_select_top #(
  parameter int MAX_DIM = lbdr_pkg::MAX_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lbdr_pkg::TILE_W-1:0]     in_target_tile,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lbdr_pkg::PORT_W-1:0]          out_port,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lbdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lbdr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TW    = lbdr_pkg::TILE_W;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = (DW > lbdr_pkg::DIM_CFG_W) ? DW : lbdr_pkg::DIM_CFG_W;
  localparam int NCELL = TW;

  logic [lbdr_pkg::DIM_CFG_W-1:0] mesh_columns_r, mesh_rows_r;
  logic [TW-1:0]                  own_tile_r;
  logic [lbdr_pkg::LINK_W-1:0]    link_healthy_r;
  logic [lbdr_pkg::TURN_W-1:0]    turn_bits_r;

  logic [CW-1:0] cols_ext, rows_ext, cols_clip, rows_clip;
  logic [DW-1:0] cols_c, rows_c;
  logic          en;
  lbdr_pkg::route_cfg_t rcfg;

  logic          st_valid   [0:NCELL];
  logic [DW-1:0] st_tgt_rem [0:NCELL];
  logic [TW-1:0] st_tgt_dq  [0:NCELL];
  logic [DW-1:0] st_own_rem [0:NCELL];
  logic [TW-1:0] st_own_dq  [0:NCELL];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mesh_columns_r <= lbdr_pkg::MESH_COLUMNS_RST;
      mesh_rows_r    <= lbdr_pkg::MESH_ROWS_RST;
      own_tile_r     <= lbdr_pkg::OWN_TILE_RST;
      link_healthy_r <= lbdr_pkg::LINK_HEALTHY_RST;
      turn_bits_r    <= lbdr_pkg::TURN_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lbdr_pkg::REG_MESH_COLUMNS: mesh_columns_r <= cfg_data[lbdr_pkg::DIM_CFG_W-1:0];
        lbdr_pkg::REG_MESH_ROWS:    mesh_rows_r    <= cfg_data[lbdr_pkg::DIM_CFG_W-1:0];
        lbdr_pkg::REG_OWN_TILE:     own_tile_r     <= cfg_data[TW-1:0];
        lbdr_pkg::REG_LINK_HEALTHY: link_healthy_r <= cfg_data[lbdr_pkg::LINK_W-1:0];
        lbdr_pkg::REG_TURN_BITS:    turn_bits_r    <= cfg_data[lbdr_pkg::TURN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_ext = CW'(mesh_columns_r);
    rows_ext = CW'(mesh_rows_r);
    if (cols_ext == '0) cols_clip = CW'(1);
    else if (cols_ext > CW'(MAX_DIM)) cols_clip = CW'(MAX_DIM);
    else cols_clip = cols_ext;
    if (rows_ext == '0) rows_clip = CW'(1);
    else if (rows_ext > CW'(MAX_DIM)) rows_clip = CW'(MAX_DIM);
    else rows_clip = rows_ext;
    cols_c = cols_clip[DW-1:0];
    rows_c = rows_clip[DW-1:0];
    rcfg.link = link_healthy_r;
    rcfg.turn = turn_bits_r;
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign st_valid[0]   = in_valid;
  assign st_tgt_rem[0] = '0;
  assign st_tgt_dq[0]  = in_target_tile;
  assign st_own_rem[0] = '0;
  assign st_own_dq[0]  = own_tile_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    lbdr_div_cell #(.DW(DW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_valid   (st_valid[i]),
      .in_tgt_rem (st_tgt_rem[i]),
      .in_tgt_dq  (st_tgt_dq[i]),
      .in_own_rem (st_own_rem[i]),
      .in_own_dq  (st_own_dq[i]),
      .divisor    (cols_c),
      .out_valid  (st_valid[i+1]),
      .out_tgt_rem(st_tgt_rem[i+1]),
      .out_tgt_dq (st_tgt_dq[i+1]),
      .out_own_rem(st_own_rem[i+1]),
      .out_own_dq (st_own_dq[i+1])
    );
  end

  lbdr_decide #(.DW(DW)) u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (st_valid[NCELL]),
    .tgt_row  (st_tgt_dq[NCELL]),
    .tgt_col  (st_tgt_rem[NCELL]),
    .own_row  (st_own_dq[NCELL]),
    .own_col  (st_own_rem[NCELL]),
    .cols     (cols_c),
    .rows     (rows_c),
    .rcfg     (rcfg),
    .out_valid(out_valid),
    .out_port (out_port)
  );

endmodule

`default_nettype wire

[hdl/lbdr_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// one restoring division step for the target lane and the own-tile lane
module lbdr_div_cell #(
  parameter int DW = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [DW-1:0]               in_tgt_rem,
  input  wire logic [lbdr_pkg::TILE_W-1:0] in_tgt_dq,
  input  wire logic [DW-1:0]               in_own_rem,
  input  wire logic [lbdr_pkg::TILE_W-1:0] in_own_dq,
  input  wire logic [DW-1:0]               divisor,
  output logic                             out_valid,
  output logic [DW-1:0]                    out_tgt_rem,
  output logic [lbdr_pkg::TILE_W-1:0]      out_tgt_dq,
  output logic [DW-1:0]                    out_own_rem,
  output logic [lbdr_pkg::TILE_W-1:0]      out_own_dq
);

  localparam int TW = lbdr_pkg::TILE_W;

  logic          valid_r;
  logic [DW-1:0] tgt_rem_r, tgt_rem_nxt, own_rem_r, own_rem_nxt;
  logic [TW-1:0] tgt_dq_r, tgt_dq_nxt, own_dq_r, own_dq_nxt;
  logic [DW:0]   tgt_trial, tgt_diff, own_trial, own_diff;
  logic          tgt_q, own_q;

  always_comb begin
    tgt_trial   = {in_tgt_rem, in_tgt_dq[TW-1]};
    tgt_diff    = tgt_trial - {1'b0, divisor};
    tgt_q       = (tgt_trial >= {1'b0, divisor});
    tgt_rem_nxt = tgt_q ? tgt_diff[DW-1:0] : tgt_trial[DW-1:0];
    tgt_dq_nxt  = {in_tgt_dq[TW-2:0], tgt_q};

    own_trial   = {in_own_rem, in_own_dq[TW-1]};
    own_diff    = own_trial - {1'b0, divisor};
    own_q       = (own_trial >= {1'b0, divisor});
    own_rem_nxt = own_q ? own_diff[DW-1:0] : own_trial[DW-1:0];
    own_dq_nxt  = {in_own_dq[TW-2:0], own_q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tgt_rem_r <= tgt_rem_nxt;
      tgt_dq_r  <= tgt_dq_nxt;
      own_rem_r <= own_rem_nxt;
      own_dq_r  <= own_dq_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_tgt_rem = tgt_rem_r;
  assign out_tgt_dq  = tgt_dq_r;
  assign out_own_rem = own_rem_r;
  assign out_own_dq  = own_dq_r;

endmodule

`default_nettype wire

[hdl/lbdr_decide.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbdr_decide #(
  parameter int DW = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [lbdr_pkg::TILE_W-1:0] tgt_row,
  input  wire logic [DW-1:0]               tgt_col,
  input  wire logic [lbdr_pkg::TILE_W-1:0] own_row,
  input  wire logic [DW-1:0]               own_col,
  input  wire logic [DW-1:0]               cols,
  input  wire logic [DW-1:0]               rows,
  input  wire lbdr_pkg::route_cfg_t        rcfg,
  output logic                             out_valid,
  output lbdr_pkg::port_t                  out_port
);

  localparam int TW   = lbdr_pkg::TILE_W;
  localparam int CMPW = (DW > TW) ? DW : TW;

  logic            valid_r;
  lbdr_pkg::port_t port_r, port_nxt;
  logic            row_eq, row_gt, col_eq, col_gt;
  logic            can_n, can_e, can_s, can_w;
  logic [DW-1:0]   cols_m1, rows_m1;

  always_comb begin
    cols_m1 = cols - DW'(1);
    rows_m1 = rows - DW'(1);
    row_eq  = (tgt_row == own_row);
    row_gt  = (tgt_row > own_row);
    col_eq  = (tgt_col == own_col);
    col_gt  = (tgt_col > own_col);
    can_n   = rcfg.link[lbdr_pkg::LINK_N] && (own_row != '0);
    can_e   = rcfg.link[lbdr_pkg::LINK_E] && (own_col != cols_m1);
    can_s   = rcfg.link[lbdr_pkg::LINK_S] && (CMPW'(own_row) < CMPW'(rows_m1));
    can_w   = rcfg.link[lbdr_pkg::LINK_W_BIT] && (own_col != '0);

    port_nxt = lbdr_pkg::PORT_NONE;
    priority if (row_eq && col_eq) begin
      port_nxt = lbdr_pkg::PORT_LOCAL;
    end else if (col_eq) begin
      if (row_gt) begin
        port_nxt = can_s ? lbdr_pkg::PORT_SOUTH : lbdr_pkg::PORT_NONE;
      end else begin
        port_nxt = can_n ? lbdr_pkg::PORT_NORTH : lbdr_pkg::PORT_NONE;
      end
    end else if (row_eq) begin
      if (col_gt) begin
        port_nxt = can_e ? lbdr_pkg::PORT_EAST : lbdr_pkg::PORT_NONE;
      end else begin
        port_nxt = can_w ? lbdr_pkg::PORT_WEST : lbdr_pkg::PORT_NONE;
      end
    end else if (!row_gt && col_gt) begin
      if (can_e && rcfg.turn[2]) port_nxt = lbdr_pkg::PORT_EAST;
      else if (can_n && rcfg.turn[0]) port_nxt = lbdr_pkg::PORT_NORTH;
    end else if (!row_gt && !col_gt) begin
      if (can_w && rcfg.turn[4]) port_nxt = lbdr_pkg::PORT_WEST;
      else if (can_n && rcfg.turn[1]) port_nxt = lbdr_pkg::PORT_NORTH;
    end else if (row_gt && !col_gt) begin
      if (can_w && rcfg.turn[5]) port_nxt = lbdr_pkg::PORT_WEST;
      else if (can_s && rcfg.turn[7]) port_nxt = lbdr_pkg::PORT_SOUTH;
    end else begin
      if (can_e && rcfg.turn[3]) port_nxt = lbdr_pkg::PORT_EAST;
      else if (can_s && rcfg.turn[6]) port_nxt = lbdr_pkg::PORT_SOUTH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      port_r <= port_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_port  = port_r;

endmodule

`default_nettype wire

[hdl/lbdr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbdr_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [lbdr_pkg::PORT_W-1:0]    out_port,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_port))
    else $error("result beat changed while stalled");

  a_port_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_port <= lbdr_pkg::PORT_NONE)
    else $error("port code out of range");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind lbdr_mesh_route_select_top lbdr_checker u_lbdr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_port (out_port),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);

`default_nettype wire
